[hdl/tree_common_ancestor_lifting_core_macros.svh]
// Assertion helpers for the checker of the common ancestor core.
`ifndef TREE_COMMON_ANCESTOR_LIFTING_CORE_MACROS_SVH
`define TREE_COMMON_ANCESTOR_LIFTING_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define TCAL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("common ancestor core: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define TCAL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("common ancestor core: next-cycle check failed");

`endif

[hdl/tcal_pkg.sv]
`default_nettype none

package tcal_pkg;

    // Sizing of the tree store
    localparam int MAX_NODES   = 65536;
    localparam int JUMP_LEVELS = 16;
    localparam int NODE_CAP    = (MAX_NODES < 65536) ? MAX_NODES : 65536;
    localparam int TOP_LEVEL   = JUMP_LEVELS - 1;

    // Field and storage widths
    localparam int ID_W    = 16;
    localparam int DEP_W   = 16;
    localparam int CNT_W   = 17;
    localparam int STAT_W  = 2;
    localparam int NODE_AW = (NODE_CAP > 1) ? $clog2(NODE_CAP) : 1;
    localparam int LVL_W   = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;
    localparam int JMP_AW  = NODE_AW + LVL_W;

    // Request codes
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NODE_ERR   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_PARENT_ERR = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_CHK,
        ST_ADD_DEP,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_QRY_CHK,
        ST_QRY_DEP,
        ST_LIFT,
        ST_LIFT_WB,
        ST_MEET_INIT,
        ST_MEET_RD,
        ST_MEET_CMP,
        ST_MEET_FIN,
        ST_MEET_OUT
    } st_t;

    // Jump memory address: node in the upper bits, level in the lower bits
    function automatic logic [JMP_AW-1:0] jump_addr(input logic [ID_W-1:0] node,
                                                    input logic [LVL_W-1:0] lvl);
        jump_addr = {node[NODE_AW-1:0], lvl};
    endfunction

endpackage

`default_nettype wire

[hdl/tcal_ram.sv]
`default_nettype none

module tcal_ram #(
    parameter int AW = 16,
    parameter int DW = 16
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr_a,
    input  wire logic [AW-1:0] raddr_b,
    output logic      [DW-1:0] rdata_a,
    output logic      [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [2**AW];

    // Write one entry, register both reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

[hdl/tree_common_ancestor_lifting_core.sv]
// Add request: checks the node (and the parent, but for the root), records the depth and
// first-level parent, then fills each higher level by a jump read and a write; a rejected
// request strobes done from the check. Query request: checks both nodes, reads their depths,
// lifts the deeper one and answers if they then coincide, else walks the jump levels down to meet.
// One request at a time: busy is high from acceptance until the done strobe cycle, in which
// the next request can be taken; results cannot be stalled. Reset clears the sequencer and
// the loaded node count; memory contents are left as they are.
`default_nettype none

module tree_common_ancestor_lifting_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         cmd,
    input  wire logic [tcal_pkg::ID_W-1:0]    node_id,
    input  wire logic [tcal_pkg::ID_W-1:0]    parent_id,
    input  wire logic [tcal_pkg::ID_W-1:0]    other_id,
    output logic                              done,
    output logic      [tcal_pkg::ID_W-1:0]    ancestor_node,
    output logic      [tcal_pkg::STAT_W-1:0]  status
);

    import tcal_pkg::*;

    // Sequencer and count
    st_t               state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic              done_reg,  done_next;

    // Request and working registers
    logic [ID_W-1:0]   node_reg,  node_next;
    logic [ID_W-1:0]   par_reg,   par_next;
    logic [ID_W-1:0]   oth_reg,   oth_next;
    logic [ID_W-1:0]   u_reg,     u_next;
    logic [ID_W-1:0]   v_reg,     v_next;
    logic [DEP_W-1:0]  gap_reg,   gap_next;
    logic [LVL_W-1:0]  lvl_reg,   lvl_next;
    logic [ID_W-1:0]   anc_reg,   anc_next;
    logic [STAT_W-1:0] stat_reg,  stat_next;

    // Memory ports
    logic              j_we;
    logic [JMP_AW-1:0] j_waddr, j_raddr_a, j_raddr_b;
    logic [ID_W-1:0]   j_wdata, jq_a, jq_b;
    logic              d_we;
    logic [NODE_AW-1:0] d_waddr, d_raddr_a, d_raddr_b;
    logic [DEP_W-1:0]  d_wdata, dq_a, dq_b;

    // Decision terms
    logic              acc;
    logic              add_bad, par_bad, is_root, q_bad, a_deeper;
    logic              lvl_top, lvl_zero, lift_take, differ;
    logic [DEP_W-1:0]  gap_sel;

    tcal_ram #(.AW(JMP_AW), .DW(ID_W)) u_jump_ram (
        .clk     (clk),
        .we      (j_we),
        .waddr   (j_waddr),
        .wdata   (j_wdata),
        .raddr_a (j_raddr_a),
        .raddr_b (j_raddr_b),
        .rdata_a (jq_a),
        .rdata_b (jq_b)
    );

    tcal_ram #(.AW(NODE_AW), .DW(DEP_W)) u_depth_ram (
        .clk     (clk),
        .we      (d_we),
        .waddr   (d_waddr),
        .wdata   (d_wdata),
        .raddr_a (d_raddr_a),
        .raddr_b (d_raddr_b),
        .rdata_a (dq_a),
        .rdata_b (dq_b)
    );

    // Decode conditions
    assign acc       = start && !busy;
    assign add_bad   = ({1'b0, node_reg} != cnt_reg) || (cnt_reg >= CNT_W'(NODE_CAP));
    assign par_bad   = ({1'b0, par_reg} >= cnt_reg);
    assign is_root   = (node_reg == '0);
    assign q_bad     = ({1'b0, node_reg} >= cnt_reg) || ({1'b0, oth_reg} >= cnt_reg);
    assign a_deeper  = (dq_a > dq_b);
    assign lvl_top   = (lvl_reg == LVL_W'(TOP_LEVEL));
    assign lvl_zero  = (lvl_reg == '0);
    assign gap_sel   = gap_reg >> lvl_reg;
    assign lift_take = lvl_top ? ((gap_reg >> TOP_LEVEL) != '0) : gap_sel[0];
    assign differ    = (jq_a != jq_b);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    state_next = (cmd == CMD_ADD) ? ST_ADD_CHK : ST_QRY_CHK;
                end
            end
            ST_ADD_CHK:
            begin
                if (add_bad)
                begin
                    state_next = ST_IDLE;
                end
                else if (is_root)
                begin
                    state_next = (TOP_LEVEL == 0) ? ST_IDLE : ST_ADD_RD;
                end
                else if (par_bad)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_ADD_DEP;
                end
            end
            ST_ADD_DEP:   state_next = (TOP_LEVEL == 0) ? ST_IDLE : ST_ADD_RD;
            ST_ADD_RD:    state_next = ST_ADD_WR;
            ST_ADD_WR:    state_next = lvl_top ? ST_IDLE : ST_ADD_RD;
            ST_QRY_CHK:   state_next = q_bad ? ST_IDLE : ST_QRY_DEP;
            ST_QRY_DEP:   state_next = ST_LIFT;
            ST_LIFT:
            begin
                if (lift_take)
                begin
                    state_next = ST_LIFT_WB;
                end
                else if (lvl_zero)
                begin
                    state_next = ST_MEET_INIT;
                end
            end
            ST_LIFT_WB:   state_next = ST_LIFT;
            ST_MEET_INIT: state_next = (u_reg == v_reg) ? ST_IDLE : ST_MEET_RD;
            ST_MEET_RD:   state_next = ST_MEET_CMP;
            ST_MEET_CMP:
            begin
                if (differ && lvl_top)
                begin
                    state_next = ST_MEET_RD;
                end
                else if (lvl_zero)
                begin
                    state_next = ST_MEET_FIN;
                end
                else
                begin
                    state_next = ST_MEET_RD;
                end
            end
            ST_MEET_FIN:  state_next = ST_MEET_OUT;
            ST_MEET_OUT:  state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        node_next = node_reg;
        par_next  = par_reg;
        oth_next  = oth_reg;
        u_next    = u_reg;
        v_next    = v_reg;
        gap_next  = gap_reg;
        lvl_next  = lvl_reg;
        anc_next  = anc_reg;
        stat_next = stat_reg;
        j_we      = 1'b0;
        j_waddr   = jump_addr(node_reg, lvl_reg);
        j_wdata   = jq_a;
        j_raddr_a = jump_addr(u_reg, lvl_reg);
        j_raddr_b = jump_addr(v_reg, lvl_reg);
        d_we      = 1'b0;
        d_waddr   = node_reg[NODE_AW-1:0];
        d_wdata   = dq_a + DEP_W'(1);
        d_raddr_a = node_reg[NODE_AW-1:0];
        d_raddr_b = oth_reg[NODE_AW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                // Latch the request
                if (acc)
                begin
                    node_next = node_id;
                    par_next  = parent_id;
                    oth_next  = other_id;
                end
            end
            ST_ADD_CHK:
            begin
                if (add_bad)
                begin
                    done_next = 1'b1;
                    anc_next  = node_reg;
                    stat_next = STAT_NODE_ERR;
                end
                else if (is_root)
                begin
                    // Root is its own parent at depth zero
                    d_we     = 1'b1;
                    d_waddr  = '0;
                    d_wdata  = '0;
                    j_we     = 1'b1;
                    j_waddr  = jump_addr('0, '0);
                    j_wdata  = '0;
                    u_next   = '0;
                    lvl_next = LVL_W'(1);
                    if (TOP_LEVEL == 0)
                    begin
                        done_next = 1'b1;
                        anc_next  = node_reg;
                        stat_next = STAT_OK;
                        cnt_next  = cnt_reg + CNT_W'(1);
                    end
                end
                else if (par_bad)
                begin
                    done_next = 1'b1;
                    anc_next  = node_reg;
                    stat_next = STAT_PARENT_ERR;
                end
                else
                begin
                    d_raddr_a = par_reg[NODE_AW-1:0];
                end
            end
            ST_ADD_DEP:
            begin
                // Record depth and first-level parent
                d_we     = 1'b1;
                d_waddr  = node_reg[NODE_AW-1:0];
                d_wdata  = dq_a + DEP_W'(1);
                j_we     = 1'b1;
                j_waddr  = jump_addr(node_reg, '0);
                j_wdata  = par_reg;
                u_next   = par_reg;
                lvl_next = LVL_W'(1);
                if (TOP_LEVEL == 0)
                begin
                    done_next = 1'b1;
                    anc_next  = node_reg;
                    stat_next = STAT_OK;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end
            ST_ADD_RD:
            begin
                // Fetch the previous level's jump of the previous ancestor
                j_raddr_a = jump_addr(u_reg, lvl_reg - LVL_W'(1));
            end
            ST_ADD_WR:
            begin
                j_we     = 1'b1;
                j_waddr  = jump_addr(node_reg, lvl_reg);
                j_wdata  = jq_a;
                u_next   = jq_a;
                lvl_next = lvl_reg + LVL_W'(1);
                if (lvl_top)
                begin
                    done_next = 1'b1;
                    anc_next  = node_reg;
                    stat_next = STAT_OK;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end
            ST_QRY_CHK:
            begin
                if (q_bad)
                begin
                    done_next = 1'b1;
                    anc_next  = '0;
                    stat_next = STAT_NODE_ERR;
                end
                else
                begin
                    d_raddr_a = node_reg[NODE_AW-1:0];
                    d_raddr_b = oth_reg[NODE_AW-1:0];
                end
            end
            ST_QRY_DEP:
            begin
                // Pick the deeper node for lifting
                if (a_deeper)
                begin
                    u_next   = node_reg;
                    v_next   = oth_reg;
                    gap_next = dq_a - dq_b;
                end
                else
                begin
                    u_next   = oth_reg;
                    v_next   = node_reg;
                    gap_next = dq_b - dq_a;
                end
                lvl_next = LVL_W'(TOP_LEVEL);
            end
            ST_LIFT:
            begin
                if (lift_take)
                begin
                    j_raddr_a = jump_addr(u_reg, lvl_reg);
                    gap_next  = gap_reg - (DEP_W'(1) << lvl_reg);
                end
                else if (lvl_zero)
                begin
                    lvl_next = LVL_W'(TOP_LEVEL);
                end
                else
                begin
                    lvl_next = lvl_reg - LVL_W'(1);
                end
            end
            ST_LIFT_WB:
            begin
                u_next = jq_a;
            end
            ST_MEET_INIT:
            begin
                if (u_reg == v_reg)
                begin
                    done_next = 1'b1;
                    anc_next  = u_reg;
                    stat_next = STAT_OK;
                end
            end
            ST_MEET_RD:
            begin
                j_raddr_a = jump_addr(u_reg, lvl_reg);
                j_raddr_b = jump_addr(v_reg, lvl_reg);
            end
            ST_MEET_CMP:
            begin
                // Advance both while their ancestors still differ
                if (differ)
                begin
                    u_next = jq_a;
                    v_next = jq_b;
                end
                if (!(differ && lvl_top) && !lvl_zero)
                begin
                    lvl_next = lvl_reg - LVL_W'(1);
                end
            end
            ST_MEET_FIN:
            begin
                j_raddr_a = jump_addr(u_reg, '0);
            end
            ST_MEET_OUT:
            begin
                done_next = 1'b1;
                anc_next  = jq_a;
                stat_next = STAT_OK;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        par_reg  <= par_next;
        oth_reg  <= oth_next;
        u_reg    <= u_next;
        v_reg    <= v_next;
        gap_reg  <= gap_next;
        lvl_reg  <= lvl_next;
        anc_reg  <= anc_next;
        stat_reg <= stat_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign ancestor_node = anc_reg;
    assign status        = stat_reg;

endmodule

`default_nettype wire

[hdl/tcal_checker.sv]
`default_nettype none

`include "tree_common_ancestor_lifting_core_macros.svh"

module tcal_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);

    // An accepted request holds the core busy on the next cycle
    `TCAL_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

    // No request completes in the cycle right after acceptance
    `TCAL_ASSERT_NEXT(a_accept_no_done, start && !busy, !done)

    // Busy drops exactly with the result strobe
    `TCAL_ASSERT_NOW(a_busy_fall_done, $fell(busy), done)

    // One strobe per request
    `TCAL_ASSERT_NEXT(a_done_single, done, !done)

endmodule

bind tree_common_ancestor_lifting_core tcal_checker u_tcal_checker (.*);

`default_nettype wire

[tb/sv/tree_common_ancestor_lifting_core_tb.sv]
`default_nettype none

module tree_common_ancestor_lifting_core_tb;

    import tcal_pkg::*;

    // Expected answer for one request
    typedef struct packed {
        logic [ID_W-1:0]   node;
        logic [STAT_W-1:0] stat;
    } answer_t;

    // One row of the directed stimulus; typed rows carry their own answer
    typedef struct packed {
        logic            op;
        logic [ID_W-1:0] node;
        logic [ID_W-1:0] parent;
        logic [ID_W-1:0] other;
        bit              typed;
        answer_t         want;
    } request_row_t;

    // Ancestor row of one node: entry i is the 2^i-th ancestor
    typedef logic [JUMP_LEVELS-1:0][ID_W-1:0] jump_row_t;

    localparam int DIRECTED_COUNT = 25;
    localparam int PHASE_ITEMS    = 256;

    localparam request_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // empty tree: query and adds that are out of order
        '{CMD_QUERY, 16'h0000, 16'h0000, 16'h0000, 1'b1, '{16'h0000, STAT_NODE_ERR}},
        '{CMD_ADD,   16'h0001, 16'h0000, 16'h0000, 1'b1, '{16'h0001, STAT_NODE_ERR}},
        '{CMD_ADD,   16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, '{16'hFFFF, STAT_NODE_ERR}},
        // root ignores its parent field
        '{CMD_ADD,   16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, '{16'h0000, STAT_OK}},
        '{CMD_ADD,   16'h0000, 16'h0000, 16'h0000, 1'b1, '{16'h0000, STAT_NODE_ERR}},
        // node naming itself, parent out of range
        '{CMD_ADD,   16'h0001, 16'h0001, 16'h0000, 1'b1, '{16'h0001, STAT_PARENT_ERR}},
        '{CMD_ADD,   16'h0001, 16'hFFFF, 16'h0000, 1'b1, '{16'h0001, STAT_PARENT_ERR}},
        '{CMD_QUERY, 16'h0000, 16'hFFFF, 16'h0000, 1'b1, '{16'h0000, STAT_OK}},
        // small tree: chain 0-1-2-3-6-7 and branch 0-4-5
        '{CMD_ADD,   16'h0001, 16'h0000, 16'h0000, 1'b1, '{16'h0001, STAT_OK}},
        '{CMD_ADD,   16'h0002, 16'h0001, 16'h0000, 1'b1, '{16'h0002, STAT_OK}},
        '{CMD_ADD,   16'h0003, 16'h0002, 16'h0000, 1'b1, '{16'h0003, STAT_OK}},
        '{CMD_ADD,   16'h0004, 16'h0000, 16'h0000, 1'b1, '{16'h0004, STAT_OK}},
        '{CMD_ADD,   16'h0005, 16'h0004, 16'h0000, 1'b1, '{16'h0005, STAT_OK}},
        '{CMD_ADD,   16'h0006, 16'h0003, 16'h0000, 1'b1, '{16'h0006, STAT_OK}},
        '{CMD_ADD,   16'h0007, 16'h0006, 16'hFFFF, 1'b1, '{16'h0007, STAT_OK}},
        // queries: different branches, same node, ancestor on either side
        '{CMD_QUERY, 16'h0007, 16'h0000, 16'h0005, 1'b0, '{16'h0000, STAT_OK}},
        '{CMD_QUERY, 16'h0003, 16'h0000, 16'h0003, 1'b0, '{16'h0000, STAT_OK}},
        '{CMD_QUERY, 16'h0002, 16'h0000, 16'h0007, 1'b0, '{16'h0000, STAT_OK}},
        '{CMD_QUERY, 16'h0007, 16'h0000, 16'h0002, 1'b0, '{16'h0000, STAT_OK}},
        '{CMD_QUERY, 16'h0000, 16'h0000, 16'h0007, 1'b0, '{16'h0000, STAT_OK}},
        // queries naming unloaded nodes, then adds with an unloaded and a loaded parent
        '{CMD_QUERY, 16'h0008, 16'h0000, 16'h0000, 1'b1, '{16'h0000, STAT_NODE_ERR}},
        '{CMD_QUERY, 16'h0000, 16'h0000, 16'h0008, 1'b1, '{16'h0000, STAT_NODE_ERR}},
        '{CMD_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, '{16'h0000, STAT_NODE_ERR}},
        '{CMD_ADD,   16'h0008, 16'h0008, 16'h0000, 1'b1, '{16'h0008, STAT_PARENT_ERR}},
        '{CMD_ADD,   16'h0008, 16'h0007, 16'h0000, 1'b1, '{16'h0008, STAT_OK}}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                cmd;
    logic [ID_W-1:0]     node_id;
    logic [ID_W-1:0]     parent_id;
    logic [ID_W-1:0]     other_id;
    logic                done;
    logic [ID_W-1:0]     ancestor_node;
    logic [STAT_W-1:0]   status;

    // Tree mirror: one jump row and one depth per loaded node
    jump_row_t           ancestor_rows[$];
    logic [DEP_W-1:0]    node_depth[$];
    answer_t             pending_answers[$];
    int                  mismatch_count = 0;

    tree_common_ancestor_lifting_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .node_id       (node_id),
        .parent_id     (parent_id),
        .other_id      (other_id),
        .done          (done),
        .ancestor_node (ancestor_node),
        .status        (status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Climb a node by a depth gap, repeating the top jump for long gaps
    function automatic logic [ID_W-1:0] climb(input logic [ID_W-1:0] v, input int unsigned gap);
        int unsigned reps;
        reps = gap >> TOP_LEVEL;
        while (reps > 0)
        begin
            v = ancestor_rows[v][TOP_LEVEL];
            reps--;
        end
        for (int i = TOP_LEVEL - 1; i >= 0; i--)
        begin
            if (((gap >> i) & 1) != 0)
                v = ancestor_rows[v][i];
        end
        return v;
    endfunction

    // Descend by halving jumps from two nodes at equal depth
    function automatic logic [ID_W-1:0] converge(input logic [ID_W-1:0] a,
                                                 input logic [ID_W-1:0] b);
        if (a == b)
            return a;
        while (ancestor_rows[a][TOP_LEVEL] != ancestor_rows[b][TOP_LEVEL])
        begin
            a = ancestor_rows[a][TOP_LEVEL];
            b = ancestor_rows[b][TOP_LEVEL];
        end
        for (int i = TOP_LEVEL - 1; i >= 0; i--)
        begin
            if (ancestor_rows[a][i] != ancestor_rows[b][i])
            begin
                a = ancestor_rows[a][i];
                b = ancestor_rows[b][i];
            end
        end
        return ancestor_rows[a][0];
    endfunction

    // Work out the answer to one request and update the tree mirror
    function automatic answer_t predict_answer(input logic op, input logic [ID_W-1:0] a,
                                               input logic [ID_W-1:0] p,
                                               input logic [ID_W-1:0] b);
        answer_t          ans;
        jump_row_t        row;
        logic [DEP_W-1:0] da;
        logic [DEP_W-1:0] db;
        logic [DEP_W-1:0] dn;
        int unsigned      loaded;
        loaded = ancestor_rows.size();
        if (op == CMD_ADD)
        begin
            ans.node = a;
            if (a != loaded || loaded >= NODE_CAP)
                ans.stat = STAT_NODE_ERR;
            else if (a != 0 && p >= loaded)
                ans.stat = STAT_PARENT_ERR;
            else if (a == 0)
            begin
                ans.stat = STAT_OK;
                row = '0;
                dn  = '0;
                ancestor_rows = {ancestor_rows, row};
                node_depth    = {node_depth, dn};
            end
            else
            begin
                ans.stat = STAT_OK;
                row[0] = p;
                for (int i = 1; i < JUMP_LEVELS; i++)
                    row[i] = ancestor_rows[row[i-1]][i-1];
                dn = node_depth[p] + 1'b1;
                node_depth    = {node_depth, dn};
                ancestor_rows = {ancestor_rows, row};
            end
        end
        else if (a >= loaded || b >= loaded)
        begin
            ans.node = '0;
            ans.stat = STAT_NODE_ERR;
        end
        else
        begin
            da = node_depth[a];
            db = node_depth[b];
            if (da > db)
                a = climb(a, da - db);
            else
                b = climb(b, db - da);
            ans.node = converge(a, b);
            ans.stat = STAT_OK;
        end
        return ans;
    endfunction

    // Present one request, hold it until accepted, then queue its answer
    task automatic issue(input logic op, input logic [ID_W-1:0] a, input logic [ID_W-1:0] p,
                         input logic [ID_W-1:0] b, input bit typed, input answer_t typed_want,
                         input int idle_pct);
        answer_t want;
        @(negedge clk);
        if ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(120, 1)) @(negedge clk);
        end
        start     <= 1'b1;
        cmd       <= op;
        node_id   <= a;
        parent_id <= p;
        other_id  <= b;
        do
            @(posedge clk);
        while (busy);
        want = predict_answer(op, a, p, b);
        if (typed)
            want = typed_want;
        pending_answers = {pending_answers, want};
    endtask

    // Drop start and hold off until every answer is back
    task automatic drain_answers();
        @(negedge clk);
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    // Random request: mostly well-formed adds and queries, some broken ones
    task automatic random_request(input int idle_pct);
        int unsigned     loaded;
        int unsigned     roll;
        int unsigned     pick;
        logic [ID_W-1:0] a;
        logic [ID_W-1:0] p;
        logic [ID_W-1:0] b;
        loaded = ancestor_rows.size();
        roll   = $urandom_range(99, 0);
        a      = ID_W'($urandom);
        p      = ID_W'($urandom);
        b      = ID_W'($urandom);
        if (roll < 40)
        begin
            // grow the tree; favor the newest node to build deep chains
            a    = ID_W'(loaded);
            pick = $urandom_range(3, 0);
            if (pick < 2)
                p = ID_W'(loaded - 1);
            else if (pick == 2)
                p = ID_W'($urandom_range(loaded - 1, (loaded > 8) ? loaded - 8 : 0));
            else
                p = ID_W'($urandom_range(loaded - 1, 0));
            issue(CMD_ADD, a, p, b, 1'b0, '0, idle_pct);
        end
        else if (roll < 85)
        begin
            a = ID_W'($urandom_range(loaded - 1, 0));
            if ($urandom_range(4, 0) == 0)
                b = a;
            else if ($urandom_range(1, 0) == 0)
                b = ID_W'($urandom_range(loaded - 1, (loaded > 16) ? loaded - 16 : 0));
            else
                b = ID_W'($urandom_range(loaded - 1, 0));
            issue(CMD_QUERY, a, p, b, 1'b0, '0, idle_pct);
        end
        else if (roll < 90)
        begin
            issue(CMD_ADD, a, p, b, 1'b0, '0, idle_pct);
        end
        else if (roll < 95)
        begin
            a = ID_W'(loaded);
            p = ID_W'($urandom_range(65535, loaded));
            issue(CMD_ADD, a, p, b, 1'b0, '0, idle_pct);
        end
        else
        begin
            if ($urandom_range(1, 0) == 0)
            begin
                a = ID_W'($urandom_range(65535, loaded));
                b = ID_W'($urandom_range(loaded - 1, 0));
            end
            else
            begin
                a = ID_W'($urandom_range(loaded - 1, 0));
                b = ID_W'($urandom_range(65535, loaded));
            end
            issue(CMD_QUERY, a, p, b, 1'b0, '0, idle_pct);
        end
    endtask

    // Compare each strobed result with the oldest queued answer
    always @(posedge clk)
    begin : result_check
        answer_t want;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
                report_mismatch($sformatf("result node %0d status %0d with no request open",
                                          ancestor_node, status));
            else
            begin
                want = pending_answers.pop_front();
                if (ancestor_node !== want.node)
                    report_mismatch($sformatf("ancestor_node got %0d, expected %0d",
                                              ancestor_node, want.node));
                if (status !== want.stat)
                    report_mismatch($sformatf("status got %0d, expected %0d",
                                              status, want.stat));
            end
        end
    end

    // Stimulus: reset, directed rows, then random phases
    initial
    begin : stimulus
        int idle_pct [4];
        idle_pct  = '{0, 81, 36, 0};
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = CMD_ADD;
        node_id   = '0;
        parent_id = '0;
        other_id  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED_ROWS[i])
            issue(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].node, DIRECTED_ROWS[i].parent,
                  DIRECTED_ROWS[i].other, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want, 0);
        drain_answers();

        foreach (idle_pct[ph])
        begin
            repeat (PHASE_ITEMS) random_request(idle_pct[ph]);
            drain_answers();
        end

        // let any stray strobe show up before closing
        repeat (100) @(posedge clk);
        if (pending_answers.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_answers.size()));
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Timeout
    initial
    begin
        #8000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
